/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define PAID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define PAID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/paid_pkg.sv */
// ----------------------------------------------------------------------------
// paid_pkg
// Shared constants for the positional insert/delete store: sizes, request
// codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package paid_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = 6;
  localparam int COUNT_W = 7;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_DELETE  = 2'd1;
  localparam logic [1:0] REQ_READOUT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

endpackage

`default_nettype wire

/* rtl/paid_ram.sv */
// ----------------------------------------------------------------------------
// paid_ram
// Generic single-write, single-read synchronous RAM. The read data is
// registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module paid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/positional_array_insert_delete_unit.sv */
// ----------------------------------------------------------------------------
// positional_array_insert_delete_unit
// Packed ordered store of signed words held in one synchronous RAM, with
// insert and delete at a 1-based position and an in-order read-out.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_stall  | req_type, data_word, position
//  out      | out_valid / out_stall| status, entry_count, entry_value,
//           |                      | entry_index, last
//
// Request flow: a rejected request goes straight to its result. Insert shifts
// the entries from the position on up one slot (no shift when appending at the
// end) and then writes the new word; delete shifts the later entries down one
// slot (no shift for the last entry); one entry is moved per cycle.
// Read-out does a RAM read and then an output load for each entry in turn.
// Reset clears the count and the control state; the RAM is not cleared.
// in_stall is high while a request is being worked on; out_stall only holds
// the output register and the sequencer waiting to load it.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_insert_delete_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] data_word,
  input  wire logic [6:0]  position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [6:0]       entry_count,
  output logic [31:0]      entry_value,
  output logic [5:0]       entry_index,
  output logic             last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_RDW   = 3'd6;

  logic [2:0]                      state;
  logic [paid_pkg::COUNT_W-1:0]    count;
  logic [paid_pkg::ADDR_W-1:0]     rd_ptr;
  logic [paid_pkg::ADDR_W-1:0]     end_ptr;
  logic [paid_pkg::ADDR_W-1:0]     pa;
  logic [paid_pkg::ADDR_W-1:0]     p0;
  logic                            pend;
  logic                            ins;
  logic [paid_pkg::DATA_W-1:0]     word;
  logic [1:0]                      res_status;

  logic                            ram_we;
  logic [paid_pkg::ADDR_W-1:0]     ram_waddr;
  logic [paid_pkg::DATA_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [paid_pkg::DATA_W-1:0]     ram_rdata;

  logic                            in_acc;
  logic                            out_free;
  logic                            out_load;
  logic                            is_full;
  logic                            ins_bad;
  logic                            del_bad;
  logic [paid_pkg::ADDR_W-1:0]     pos0;
  logic [paid_pkg::ADDR_W-1:0]     cnt_m1;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_EMIT) || (state == S_RDW));

  assign is_full = (count == paid_pkg::COUNT_W'(paid_pkg::DEPTH));
  assign ins_bad = (position == 7'd0) || ({1'b0, position} > ({1'b0, count} + 8'd1));
  assign del_bad = (position == 7'd0) || (position > count);
  assign pos0    = paid_pkg::ADDR_W'(position - 7'd1);
  assign cnt_m1  = paid_pkg::ADDR_W'(count - 7'd1);

  // Shifting reads one entry per cycle and writes it back one slot over in
  // the following cycle; the write never hits an address still to be read.
  assign ram_re    = (state == S_SHIFT) || (state == S_RD);
  assign ram_we    = (((state == S_SHIFT) || (state == S_DRAIN)) && pend) ||
                     (state == S_PUT);
  assign ram_waddr = (state == S_PUT) ? p0 :
                     (ins ? pa + paid_pkg::ADDR_W'(1) : pa - paid_pkg::ADDR_W'(1));
  assign ram_wdata = (state == S_PUT) ? word : ram_rdata;

  paid_ram #(
    .WIDTH(paid_pkg::DATA_W),
    .DEPTH(paid_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // A new result may load in the same cycle the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            word <= data_word;
            p0   <= pos0;
            pend <= 1'b0;
            case (req_type)
              paid_pkg::REQ_INSERT: begin
                ins <= 1'b1;
                if (is_full) begin
                  res_status <= paid_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else if (ins_bad) begin
                  res_status <= paid_pkg::ST_INVALID;
                  state      <= S_EMIT;
                end else begin
                  res_status <= paid_pkg::ST_OK;
                  rd_ptr     <= cnt_m1;
                  end_ptr    <= pos0;
                  // Appending at the end needs no shift.
                  state      <= ({1'b0, pos0} == count) ? S_PUT : S_SHIFT;
                end
              end
              paid_pkg::REQ_DELETE: begin
                ins <= 1'b0;
                if (count == '0) begin
                  res_status <= paid_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else if (del_bad) begin
                  res_status <= paid_pkg::ST_INVALID;
                  state      <= S_EMIT;
                end else begin
                  res_status <= paid_pkg::ST_OK;
                  rd_ptr     <= pos0 + paid_pkg::ADDR_W'(1);
                  end_ptr    <= cnt_m1;
                  if (position == count) begin
                    count <= count - 7'd1;
                    state <= S_EMIT;
                  end else begin
                    state <= S_SHIFT;
                  end
                end
              end
              paid_pkg::REQ_READOUT: begin
                rd_ptr <= '0;
                if (count == '0) begin
                  res_status <= paid_pkg::ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  state <= S_RD;
                end
              end
              default: begin
                res_status <= paid_pkg::ST_INVALID;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_SHIFT: begin
          pend <= 1'b1;
          pa   <= rd_ptr;
          if (rd_ptr == end_ptr) begin
            state <= S_DRAIN;
          end else begin
            rd_ptr <= ins ? rd_ptr - paid_pkg::ADDR_W'(1) : rd_ptr + paid_pkg::ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          if (ins) begin
            state <= S_PUT;
          end else begin
            count <= count - 7'd1;
            state <= S_EMIT;
          end
        end
        S_PUT: begin
          count <= count + 7'd1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            status      <= res_status;
            entry_count <= count;
            entry_value <= '0;
            entry_index <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          if (out_free) begin
            status      <= paid_pkg::ST_OK;
            entry_count <= count;
            entry_value <= ram_rdata;
            entry_index <= rd_ptr;
            last        <= (rd_ptr == cnt_m1);
            if (rd_ptr == cnt_m1) begin
              state <= S_IDLE;
            end else begin
              rd_ptr <= rd_ptr + paid_pkg::ADDR_W'(1);
              state  <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/paid_checker.sv */
// ----------------------------------------------------------------------------
// paid_checker
// Port-level checks on the positional insert/delete store, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module paid_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  req_type,
  input wire logic [31:0] data_word,
  input wire logic [6:0]  position,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [6:0]  entry_count,
  input wire logic [31:0] entry_value,
  input wire logic [5:0]  entry_index,
  input wire logic        last
);

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^req_type) ^ (^data_word) ^ (^position);

  // A stalled result must be held unchanged.
  `PAID_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(entry_value) && $stable(entry_index) && $stable(last), "stalled result changed")

  // Any failing status ends its request with a single result.
  `PAID_ASSERT_NOW(a_err_last, out_valid && (status != paid_pkg::ST_OK), last && (entry_value == 32'd0) && (entry_index == 6'd0), "error result not a lone final result")

  // The store never reports more entries than it can hold.
  `PAID_ASSERT_NOW(a_count_max, out_valid, entry_count <= 7'd64, "entry count beyond depth")

  // A read-out entry lies inside the held range.
  `PAID_ASSERT_NOW(a_index_range, out_valid && (status == paid_pkg::ST_OK) && (entry_index != 6'd0), {1'b0, entry_index} < entry_count, "entry index beyond count")

endmodule

bind positional_array_insert_delete_unit paid_checker u_paid_checker (.*);

`default_nettype wire
